[hdl/amrk_pkg.sv]
// Package for the meter autorange key controller.
// Holds the range tables, field widths and the types shared by the core and the result queue.
// No dependencies.
package amrk_pkg;

    localparam int NUM_RANGES    = 7;
    localparam int RANGE_W       = 3;
    localparam int MAX_RES       = 3;
    localparam int RES_CNT_W     = 2;
    localparam int TICK_W        = 16;
    localparam logic [TICK_W-1:0] AUTO_INTERVAL_RST = 16'h3FF0;
    localparam logic [7:0] KEYS_IDLE = 8'hFF;
    localparam logic [7:0] KEY_AUTO  = 8'h01;

    // Relay drive pattern per range; range seven drives nothing
    localparam logic [7:0] RELAY_TAB [8] = '{
        8'h60, 8'h50, 8'h48, 8'h44, 8'h42, 8'h41, 8'h01, 8'h00
    };

    // Range indicator pattern per range; bit 0 is left free for the auto mark
    localparam logic [7:0] DISP_TAB [8] = '{
        8'h48, 8'h88, 8'h24, 8'h44, 8'h84, 8'h22, 8'h42, 8'h00
    };

    typedef struct packed {
        logic [7:0] relay_byte;
        logic [7:0] display_byte;
    } amrk_res_t;

    // All updates caused by one tick, in order from entry 0 up
    typedef struct packed {
        logic [RES_CNT_W-1:0]         count;
        amrk_res_t [MAX_RES-1:0]      ent;
    } amrk_batch_t;

    function automatic amrk_res_t amrk_pattern(input logic [RANGE_W-1:0] rng,
                                               input logic auto_on);
        amrk_res_t r;
        r.relay_byte   = RELAY_TAB[rng];
        r.display_byte = DISP_TAB[rng] | {7'b0, auto_on};
        return r;
    endfunction

endpackage

[hdl/meter_autorange_key_controller.sv]
// Meter autorange key controller, top level.
// The first update of a tick is registered in the result queue and appears in the cycle
// after the tick transfer. One tick per cycle when it gives at most one update and the
// output is not stalled; a tick with more holds off the next until its last update leaves.
// Reset: range 0, auto mode on, no key held, tick counter 0, interval 16368, queue empty.
// Depends on amrk_pkg, amrk_core and amrk_outq.
module meter_autorange_key_controller
    import amrk_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [7:0] key_lines, [8] over_range, [9] under_range
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] relay_byte, [15:8] display_byte
    output logic        m_axis_tlast    // last_of_tick
);

    amrk_batch_t batch;
    amrk_res_t   out_res;
    logic        space;
    logic        tick_en;

    assign s_axis_tready = space;
    assign tick_en       = s_axis_tvalid && space;

    amrk_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .tick_en     (tick_en),
        .key_lines   (s_axis_tdata[7:0]),
        .over_range  (s_axis_tdata[8]),
        .under_range (s_axis_tdata[9]),
        .batch       (batch)
    );

    amrk_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (tick_en),
        .batch     (batch),
        .space     (space),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (out_res),
        .out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {out_res.display_byte, out_res.relay_byte};

endmodule

[hdl/amrk_core.sv]
// Tick processing core: key latch, release decode, auto range check and tick counter.
// Computes the whole batch of updates for one tick in a single pass.
// Depends on amrk_pkg.
module amrk_core
    import amrk_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [15:0]       cfg_wdata,
    input  logic              tick_en,
    input  logic [7:0]        key_lines,
    input  logic              over_range,
    input  logic              under_range,
    output amrk_batch_t       batch
);

    logic [RANGE_W-1:0] range_reg, range_next;
    logic               auto_reg, auto_next;
    logic [7:0]         latch_reg, latch_next;
    logic               held_reg, held_next;
    logic [TICK_W-1:0]  tick_reg, tick_next;
    logic [TICK_W-1:0]  interval_reg;

    // Work out the updates and the next state for the tick on the input
    always_comb
    begin
        logic               keys_idle;
        logic [7:0]         code;
        logic               check;
        logic [RES_CNT_W-1:0] n;
        amrk_res_t [MAX_RES-1:0] ent;

        keys_idle  = (key_lines == KEYS_IDLE);
        code       = ~latch_reg;
        check      = (tick_reg > interval_reg);
        range_next = range_reg;
        auto_next  = auto_reg;
        n          = '0;
        ent        = '0;

        // Decode the latched key once all keys are released
        if (held_reg && keys_idle)
        begin
            if (code == KEY_AUTO)
            begin
                auto_next  = 1'b1;
                range_next = '0;
                ent[n]     = amrk_pattern(range_next, auto_next);
                n          = n + 1'b1;
            end
            else
            begin
                auto_next = 1'b0;
                for (int k = 0; k < 7; k++)
                begin
                    if (code == (8'h02 << k) && k < NUM_RANGES)
                    begin
                        range_next = RANGE_W'(k);
                        ent[n]     = amrk_pattern(range_next, auto_next);
                        n          = n + 1'b1;
                    end
                end
            end
        end

        held_next  = !keys_idle;
        latch_next = keys_idle ? latch_reg : key_lines;

        // Auto range check: step down on over-range, then up on under-range
        if (check && auto_next)
        begin
            if (over_range && range_next != '0)
            begin
                range_next = range_next - 1'b1;
                ent[n]     = amrk_pattern(range_next, auto_next);
                n          = n + 1'b1;
            end
            if (under_range && range_next < RANGE_W'(NUM_RANGES - 1))
            begin
                range_next = range_next + 1'b1;
                ent[n]     = amrk_pattern(range_next, auto_next);
                n          = n + 1'b1;
            end
        end

        tick_next   = check ? TICK_W'(1) : tick_reg + 1'b1;
        batch.count = n;
        batch.ent   = ent;
    end

    // Advance the state on each accepted tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_reg <= '0;
            auto_reg  <= 1'b1;
            latch_reg <= KEYS_IDLE;
            held_reg  <= 1'b0;
            tick_reg  <= '0;
        end
        else if (tick_en)
        begin
            range_reg <= range_next;
            auto_reg  <= auto_next;
            latch_reg <= latch_next;
            held_reg  <= held_next;
            tick_reg  <= tick_next;
        end
    end

    // Hold the auto check interval
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            interval_reg <= AUTO_INTERVAL_RST;
        else if (cfg_we)
            interval_reg <= cfg_wdata;
    end

endmodule

[hdl/amrk_outq.sv]
// Result queue: holds the updates of one tick and hands them out one per transfer.
// Takes a new batch while empty or in the cycle its last held entry leaves.
// Depends on amrk_pkg.
module amrk_outq
    import amrk_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         load,
    input  amrk_batch_t  batch,
    output logic         space,
    output logic         out_valid,
    input  logic         out_ready,
    output amrk_res_t    out_res,
    output logic         out_last
);

    logic [RES_CNT_W-1:0]    cnt_reg, cnt_next;
    amrk_res_t [MAX_RES-1:0] q_reg, q_next;
    logic                    pop;

    assign pop       = out_valid && out_ready;
    assign out_valid = (cnt_reg != '0);
    assign out_res   = q_reg[0];
    assign out_last  = (cnt_reg == RES_CNT_W'(1));
    // Room for a new tick once the queue is empty or drains this cycle
    assign space     = (cnt_reg == '0) || (out_last && pop);

    // Load a fresh batch, or shift down on a transfer
    always_comb
    begin
        cnt_next = cnt_reg;
        q_next   = q_reg;
        if (load)
        begin
            cnt_next = batch.count;
            q_next   = batch.ent;
        end
        else if (pop)
        begin
            cnt_next = cnt_reg - 1'b1;
            for (int i = 0; i < MAX_RES - 1; i++)
                q_next[i] = q_reg[i + 1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

endmodule
